// ----- src/stl_pkg.sv -----
// Shared types, token codes and helper functions of the source text lexer.
`default_nettype none
package stl_pkg;

  localparam int KwMaxChars = 6;
  localparam int MaxTokens  = 3;

  localparam logic [5:0] K_END     = 6'd0;
  localparam logic [5:0] K_IDENT   = 6'd1;
  localparam logic [5:0] K_INT     = 6'd2;
  localparam logic [5:0] K_DECIMAL = 6'd3;
  localparam logic [5:0] K_STRING  = 6'd4;
  localparam logic [5:0] K_BOOL    = 6'd5;
  localparam logic [5:0] K_PLUS    = 6'd18;
  localparam logic [5:0] K_MINUS   = 6'd19;
  localparam logic [5:0] K_ARROW   = 6'd20;
  localparam logic [5:0] K_STAR    = 6'd21;
  localparam logic [5:0] K_SLASH   = 6'd22;
  localparam logic [5:0] K_ASSIGN  = 6'd23;
  localparam logic [5:0] K_EQ      = 6'd24;
  localparam logic [5:0] K_BANG    = 6'd25;
  localparam logic [5:0] K_NE      = 6'd26;
  localparam logic [5:0] K_GT      = 6'd27;
  localparam logic [5:0] K_GE      = 6'd28;
  localparam logic [5:0] K_LT      = 6'd29;
  localparam logic [5:0] K_LE      = 6'd30;
  localparam logic [5:0] K_LARROW  = 6'd31;
  localparam logic [5:0] K_SEMI    = 6'd32;
  localparam logic [5:0] K_LPAREN  = 6'd33;
  localparam logic [5:0] K_RPAREN  = 6'd34;
  localparam logic [5:0] K_LBRACE  = 6'd35;
  localparam logic [5:0] K_RBRACE  = 6'd36;
  localparam logic [5:0] K_UNKNOWN = 6'd37;

  // Word table: text held with its first byte in the low byte.
  localparam logic [13:0][47:0] WordText = '{
    48'("eslaf"), 48'("eurt"), 48'("loob"), 48'("gnirts"),
    48'("elbuod"), 48'("tni"), 48'("dom"), 48'("taeper"),
    48'("esle"), 48'("file"), 48'("fi"), 48'("ni"),
    48'("tuo"), 48'("tel")
  };
  localparam logic [13:0][2:0] WordLen = '{
    3'd5, 3'd4, 3'd4, 3'd6, 3'd6, 3'd3, 3'd3, 3'd6, 3'd4, 3'd4, 3'd2, 3'd2, 3'd3, 3'd3
  };
  localparam logic [13:0][5:0] WordKind = '{
    6'd5, 6'd5, 6'd17, 6'd16, 6'd15, 6'd14, 6'd13, 6'd12, 6'd11, 6'd10, 6'd9, 6'd8,
    6'd7, 6'd6
  };

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_source;
  } src_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [23:0] start_offset;
    logic [15:0] text_length;
    logic [15:0] start_line;
    logic [15:0] start_column;
  } tok_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [23:0] start_offset;
    logic [15:0] text_length;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic        last_of_run;
  } tok_item_t;

  typedef struct packed {
    tok_t [MaxTokens-1:0] slot;
    logic [1:0]           count;
  } tok_bundle_t;

  function automatic logic [15:0] sat16_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [23:0] sat24_add(input logic [23:0] a, input logic [15:0] b);
    logic [24:0] s;
    s = {1'b0, a} + {9'd0, b};
    return s[24] ? 24'hFFFFFF : s[23:0];
  endfunction

  function automatic tok_t make_tok(input logic [5:0] kind, input logic [23:0] off,
                                    input logic [15:0] len, input logic [15:0] line,
                                    input logic [15:0] col);
    tok_t t;
    t.token_kind   = kind;
    t.start_offset = off;
    t.text_length  = len;
    t.start_line   = line;
    t.start_column = col;
    return t;
  endfunction

  // Keyword, bool or plain identifier, from the first bytes and the length.
  function automatic logic [5:0] word_kind(input logic [47:0] win, input logic [15:0] len);
    logic [5:0]  k;
    logic [47:0] mask;
    k = K_IDENT;
    for (int i = 13; i >= 0; i--) begin
      mask = 48'hFFFF_FFFF_FFFF >> (6'd48 - {WordLen[i], 3'd0});
      if (len == {13'd0, WordLen[i]} && (win & mask) == WordText[i]) begin
        k = WordKind[i];
      end
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// ----- src/stl_core.sv -----
// Lexer state and the per-byte decision logic that forms each item's token bundle.
`default_nettype none
module stl_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire stl_pkg::src_item_t  item,
  output stl_pkg::tok_bundle_t     bundle
);
  import stl_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_NUM_DOT, M_DECIMAL, M_STRING, M_COMMENT,
    M_SLASH, M_MINUS, M_EQUAL, M_BANG, M_GREATER, M_LESS
  } mode_t;

  mode_t            mode, mode_next;
  logic [15:0]      line, line_next, col, col_next, len, len_next;
  logic [23:0]      off, off_next, st_off, st_off_next;
  logic [15:0]      st_line, st_line_next, st_col, st_col_next;
  logic [5:0][7:0]  win, win_next;

  logic [7:0] c;
  logic       is_digit, is_alpha, is_space, absorbed;
  tok_t       fl0, fl1, e;
  logic [1:0] fn, flush_n;
  logic       en;
  logic [5:0] flush_kind, one_kind;
  logic [15:0] flush_len;

  always_comb begin
    c        = item.char_byte;
    is_digit = (c >= "0") && (c <= "9");
    is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    is_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));

    flush_len = 16'd1;
    flush_n   = 2'd1;
    unique case (mode)
      M_IDENT:   begin flush_kind = word_kind(win, len); flush_len = len; end
      M_NUMBER:  begin flush_kind = K_INT; flush_len = len; end
      M_NUM_DOT: begin flush_kind = K_INT; flush_len = len; flush_n = 2'd2; end
      M_DECIMAL: begin flush_kind = K_DECIMAL; flush_len = len; end
      M_STRING:  begin flush_kind = K_STRING; flush_len = len; end
      M_SLASH:   flush_kind = K_SLASH;
      M_MINUS:   flush_kind = K_MINUS;
      M_EQUAL:   flush_kind = K_ASSIGN;
      M_BANG:    flush_kind = K_BANG;
      M_GREATER: flush_kind = K_GT;
      M_LESS:    flush_kind = K_LT;
      default:   begin flush_kind = K_END; flush_n = 2'd0; end
    endcase
    fl0 = make_tok(flush_kind, st_off, flush_len, st_line, st_col);
    fl1 = make_tok(K_UNKNOWN, sat24_add(st_off, len), 16'd1, st_line, sat16_add(st_col, len));

    unique case (c)
      "+":     one_kind = K_PLUS;
      "*":     one_kind = K_STAR;
      ";":     one_kind = K_SEMI;
      "(":     one_kind = K_LPAREN;
      ")":     one_kind = K_RPAREN;
      "{":     one_kind = K_LBRACE;
      "}":     one_kind = K_RBRACE;
      default: one_kind = K_UNKNOWN;
    endcase

    mode_next = mode; line_next = line; col_next = col; off_next = off;
    st_off_next = st_off; st_line_next = st_line; st_col_next = st_col;
    len_next = len; win_next = win;
    fn = 2'd0; en = 1'b0; e = '0; absorbed = 1'b0;

    if (item.end_of_source) begin
      fn = flush_n;
      en = 1'b1;
      e  = make_tok(K_END, off, 16'd0, line, col);
      mode_next = M_IDLE; line_next = 16'd1; col_next = 16'd1; off_next = '0;
      st_off_next = '0; st_line_next = '0; st_col_next = '0;
      len_next = '0; win_next = '0;
    end else begin
      unique case (mode)
        M_IDENT: if (is_alpha || is_digit || c == "_") begin
          absorbed = 1'b1;
          if (len < 16'(KwMaxChars)) win_next[len[2:0]] = c;
          len_next = sat16_add(len, 16'd1);
        end
        M_NUMBER: if (is_digit) begin
          absorbed = 1'b1; len_next = sat16_add(len, 16'd1);
        end else if (c == ".") begin
          absorbed = 1'b1; mode_next = M_NUM_DOT;
        end
        M_NUM_DOT: if (is_digit) begin
          absorbed = 1'b1; len_next = sat16_add(len, 16'd2); mode_next = M_DECIMAL;
        end
        M_DECIMAL: if (is_digit) begin
          absorbed = 1'b1; len_next = sat16_add(len, 16'd1);
        end
        M_STRING: begin
          absorbed = 1'b1;
          if (c == "\"") begin
            en = 1'b1; e = fl0; mode_next = M_IDLE;
          end else begin
            len_next = sat16_add(len, 16'd1);
          end
        end
        M_COMMENT: begin
          absorbed = 1'b1;
          if (c == 8'h0A) mode_next = M_IDLE;
        end
        M_SLASH: if (c == "/") begin
          absorbed = 1'b1; mode_next = M_COMMENT;
        end
        M_MINUS: if (c == ">") begin
          absorbed = 1'b1; en = 1'b1; mode_next = M_IDLE;
          e = make_tok(K_ARROW, st_off, 16'd2, st_line, st_col);
        end
        M_EQUAL: if (c == "=") begin
          absorbed = 1'b1; en = 1'b1; mode_next = M_IDLE;
          e = make_tok(K_EQ, st_off, 16'd2, st_line, st_col);
        end
        M_BANG: if (c == "=") begin
          absorbed = 1'b1; en = 1'b1; mode_next = M_IDLE;
          e = make_tok(K_NE, st_off, 16'd2, st_line, st_col);
        end
        M_GREATER: if (c == "=") begin
          absorbed = 1'b1; en = 1'b1; mode_next = M_IDLE;
          e = make_tok(K_GE, st_off, 16'd2, st_line, st_col);
        end
        M_LESS: if (c == "=" || c == "-") begin
          absorbed = 1'b1; en = 1'b1; mode_next = M_IDLE;
          e = make_tok((c == "=") ? K_LE : K_LARROW, st_off, 16'd2, st_line, st_col);
        end
        default: absorbed = 1'b0;
      endcase

      if (!absorbed) begin
        fn = flush_n;
        mode_next = M_IDLE;
        if (!is_space) begin
          st_off_next = off; st_line_next = line; st_col_next = col;
          len_next = 16'd1;
          if (is_digit) begin
            mode_next = M_NUMBER;
          end else if (is_alpha || c == "_") begin
            win_next[0] = c;
            mode_next = M_IDENT;
          end else begin
            unique case (c)
              "\"": begin
                st_off_next = sat24_add(off, 16'd1);
                len_next = 16'd0;
                mode_next = M_STRING;
              end
              "/": mode_next = M_SLASH;
              "-": mode_next = M_MINUS;
              "=": mode_next = M_EQUAL;
              "!": mode_next = M_BANG;
              ">": mode_next = M_GREATER;
              "<": mode_next = M_LESS;
              default: begin
                en = 1'b1;
                e  = make_tok(one_kind, off, 16'd1, line, col);
              end
            endcase
          end
        end
      end

      if (c == 8'h0A) begin
        line_next = sat16_add(line, 16'd1);
        col_next  = 16'd1;
      end else begin
        col_next  = sat16_add(col, 16'd1);
      end
      off_next = sat24_add(off, 16'd1);
    end

    // Pack flushed tokens first, then the token this byte closes or makes.
    bundle.slot[0] = (fn != 2'd0) ? fl0 : e;
    bundle.slot[1] = (fn == 2'd2) ? fl1 : e;
    bundle.slot[2] = e;
    bundle.count   = fn + {1'b0, en};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; line <= 16'd1; col <= 16'd1; off <= '0;
      st_off <= '0; st_line <= '0; st_col <= '0; len <= '0; win <= '0;
    end else if (accept) begin
      mode <= mode_next; line <= line_next; col <= col_next; off <= off_next;
      st_off <= st_off_next; st_line <= st_line_next; st_col <= st_col_next;
      len <= len_next; win <= win_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/source_text_lexer_unit.sv -----
// Top level of the source text lexer: byte input, token bundle register, token output.
`default_nettype none
// Streaming lexer: one source byte (or an end-of-source mark) per input item,
// tokens out as soon as they are decided. A byte is taken every cycle as long
// as the tokens of the previous byte are gone or leave in that same cycle;
// one byte gives zero to three tokens, and the token port sends one per cycle
// while tok_stall is low; the token bundle register holds a byte's tokens
// until the last has left. Each token carries kind, start offset, length,
// start line and start column, and last_of_run marks the final token of one
// input item. End of source flushes the pending token, sends the end token
// and returns all counters to their start values.
module source_text_lexer_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                src_valid,
  output logic                     src_stall,
  input  wire stl_pkg::src_item_t  src_item,
  output logic                     tok_valid,
  input  wire logic                tok_stall,
  output stl_pkg::tok_item_t       tok_item
);
  import stl_pkg::*;

  tok_bundle_t core_bundle;
  tok_t [MaxTokens-1:0] slot;
  logic [1:0] count, idx;
  logic       busy;
  logic       src_take, tok_take, tok_last;

  assign tok_last  = (idx == count - 2'd1);
  assign tok_take  = busy && !tok_stall;
  // Hold the byte while tokens remain, unless the last one leaves now.
  assign src_stall = busy && !(tok_take && tok_last);
  assign src_take  = src_valid && !src_stall;

  stl_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (src_take),
    .item   (src_item),
    .bundle (core_bundle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (src_take && core_bundle.count != 2'd0) begin
      // Load the new bundle; bytes with no tokens leave the output alone.
      busy  <= 1'b1;
      idx   <= '0;
      slot  <= core_bundle.slot;
      count <= core_bundle.count;
    end else if (tok_take) begin
      if (tok_last) busy <= 1'b0;
      idx <= idx + 2'd1;
    end
  end

  always_comb begin
    tok_valid             = busy;
    tok_item.token_kind   = slot[idx].token_kind;
    tok_item.start_offset = slot[idx].start_offset;
    tok_item.text_length  = slot[idx].text_length;
    tok_item.start_line   = slot[idx].start_line;
    tok_item.start_column = slot[idx].start_column;
    tok_item.last_of_run  = tok_last;
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx < count))
    else $error("token index past bundle count");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (src_take && core_bundle.count != 2'd0) |=> (tok_valid && idx == 2'd0))
    else $error("loaded bundle not presented");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> (busy && !(tok_take && tok_last)))
    else $error("input stalled with no tokens pending");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (tok_take && tok_last && !src_take) |=> !tok_valid)
    else $error("output still valid after last token");

endmodule
`default_nettype wire
